// ----- design/pip_pkg.sv -----
// Shared types and constants for the point-in-polygon crossing test.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES      = 16;
  localparam int MIN_POLY_VERTICES = 3;
  localparam int SLOT_W            = $clog2(MAX_VERTICES);
  localparam int CNT_W             = 5;
  localparam int COORD_W           = 32;
  localparam int DIFF_W            = COORD_W + 1;
  localparam int PROD_W            = 2 * DIFF_W;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_TEST  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_HOLD
  } state_e;

  typedef struct packed {
    func_e                      func;
    logic [3:0]                 vertex_slot;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic [CNT_W-1:0] crossing_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } rd_tag_t;

  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

endpackage
`default_nettype wire

// ----- design/pip_vtx_mem.sv -----
// Vertex store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pip_vtx_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pip_pkg::SLOT_W-1:0]    waddr_i,
  input  pip_pkg::vertex_t              wdata_i,
  input  logic                          re_i,
  input  logic [pip_pkg::SLOT_W-1:0]    raddr_i,
  output pip_pkg::vertex_t              rdata_o
);
  import pip_pkg::*;

  vertex_t mem_q [MAX_VERTICES];
  vertex_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/pip_edge_eval.sv -----
// Three-stage edge evaluator: span and differences, products, compare and count.
`timescale 1ns / 1ps
`default_nettype none
module pip_edge_eval (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            clear_i,
  input  pip_pkg::edge_ctl_t              edge_i,
  input  pip_pkg::vertex_t                v1_i,
  input  pip_pkg::vertex_t                v2_i,
  input  logic signed [pip_pkg::COORD_W-1:0] px_i,
  input  logic signed [pip_pkg::COORD_W-1:0] pz_i,
  output logic                            done_o,
  output logic [pip_pkg::CNT_W-1:0]       count_o
);
  import pip_pkg::*;

  // stage 1: span test and sign-corrected differences
  logic                      span;
  logic                      dir_neg;
  logic signed [DIFF_W-1:0]  dz_pos, dz_neg, t_pos, t_neg, a_d, dx_d;

  edge_ctl_t                 s1_q;
  logic                      s1_span_q;
  logic signed [DIFF_W-1:0]  s1_a_q, s1_dx_q, s1_dz_q, s1_t_q;

  edge_ctl_t                 s2_q;
  logic                      s2_span_q;
  logic signed [PROD_W-1:0]  s2_pl_q, s2_pr_q;

  logic                      hit;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      done_q;
  logic [CNT_W-1:0]          res_q;

  always_comb begin
    span    = ((v1_i.z <= pz_i) && (pz_i < v2_i.z)) ||
              ((v2_i.z <= pz_i) && (pz_i < v1_i.z));
    dir_neg = v2_i.z < v1_i.z;
    dz_pos  = {v2_i.z[COORD_W-1], v2_i.z} - {v1_i.z[COORD_W-1], v1_i.z};
    dz_neg  = {v1_i.z[COORD_W-1], v1_i.z} - {v2_i.z[COORD_W-1], v2_i.z};
    t_pos   = {pz_i[COORD_W-1], pz_i} - {v1_i.z[COORD_W-1], v1_i.z};
    t_neg   = {v1_i.z[COORD_W-1], v1_i.z} - {pz_i[COORD_W-1], pz_i};
    a_d     = {px_i[COORD_W-1], px_i} - {v1_i.x[COORD_W-1], v1_i.x};
    dx_d    = {v2_i.x[COORD_W-1], v2_i.x} - {v1_i.x[COORD_W-1], v1_i.x};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= edge_i;
      s2_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_span_q <= span;
    s1_a_q    <= a_d;
    s1_dx_q   <= dx_d;
    s1_dz_q   <= dir_neg ? dz_neg : dz_pos;
    s1_t_q    <= dir_neg ? t_neg  : t_pos;
  end

  // stage 2: cross products, (px - x1) * dz against (x2 - x1) * t
  always_ff @(posedge clk_i) begin
    s2_span_q <= s1_span_q;
    s2_pl_q   <= s1_a_q * s1_dz_q;
    s2_pr_q   <= s1_dx_q * s1_t_q;
  end

  // stage 3: crossing strictly right of the point
  always_comb begin
    hit     = s2_q.valid && s2_span_q && (s2_pl_q < s2_pr_q);
    count_d = count_q + CNT_W'(hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= s2_q.valid && s2_q.last;
      if (clear_i) begin
        count_q <= '0;
      end else if (s2_q.valid) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q.valid && s2_q.last) begin
      res_q <= count_d;
    end
  end

  assign done_o  = done_q;
  assign count_o = res_q;

endmodule
`default_nettype wire

// ----- design/point_in_polygon_crossing_test.sv -----
// Top level of the even-odd point-in-polygon crossing test.
// A vertex write goes straight into the vertex store; a test on n >= 3 vertices walks the
//   polygon through the edge evaluator, a test on fewer vertices goes straight to the output.
// Throughput: one test at a time; the walk reads one vertex per cycle from the single
//   read port of the vertex store (n + 1 reads, closing back at slot 0).
// Reset: vertex_count and all control state clear; vertex contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_crossing_test (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: vertex_count
  input  logic                        cfg_we_i,
  input  logic [pip_pkg::CNT_W-1:0]   cfg_wdata_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  pip_pkg::in_item_t           in_item_i,
  // result items
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output pip_pkg::out_item_t          out_item_o
);
  import pip_pkg::*;

  state_e                    state_q, state_d;

  logic [CNT_W-1:0]          vcount_q;
  logic [CNT_W-1:0]          n_clamp;
  logic [CNT_W-1:0]          n_q;
  logic [CNT_W-1:0]          cnt_q;
  logic signed [COORD_W-1:0] px_q, pz_q;
  logic [CNT_W-1:0]          res_q;

  logic                      in_acc;
  logic                      write_go;
  logic                      test_go;
  logic                      short_poly;
  logic                      rd_last;
  logic                      rd_en;
  logic [SLOT_W-1:0]         rd_addr;
  rd_tag_t                   tag_q;
  vertex_t                   wr_vtx;
  vertex_t                   rd_vtx;
  vertex_t                   prev_q;
  edge_ctl_t                 edge_ctl;

  logic                      ev_done;
  logic [CNT_W-1:0]          ev_count;

  logic                      out_free;
  logic                      load_out;
  logic                      out_valid_q;
  out_item_t                 out_item_q;

  // The vertex count register; counts above capacity are clamped at test start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    n_clamp    = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
    short_poly = n_clamp < CNT_W'(MIN_POLY_VERTICES);
    in_acc     = in_valid_i && !in_stall_o;
    write_go   = in_acc && (in_item_i.func == FUNC_WRITE);
    test_go    = in_acc && (in_item_i.func == FUNC_TEST);
    // The walk issues slots 0 .. n-1 and then slot 0 again to close the loop.
    rd_last    = cnt_q == n_q;
    rd_addr    = rd_last ? '0 : cnt_q[SLOT_W-1:0];
    out_free   = !out_valid_q || !out_stall_i;
    wr_vtx.x   = in_item_i.coord_x;
    wr_vtx.z   = in_item_i.coord_z;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (test_go) begin
          state_d = short_poly ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (rd_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (ev_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs: take items only when idle, read while walking, hand off when done.
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_RUN: begin
        rd_en = 1'b1;
      end
      ST_WAIT: begin
        in_stall_o = 1'b1;
      end
      ST_HOLD: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      if (test_go) begin
        cnt_q <= '0;
      end else if (rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      // Tag the read data that arrives in the cycle after each read.
      tag_q.valid <= rd_en;
      tag_q.first <= rd_en && (cnt_q == '0);
      tag_q.last  <= rd_en && rd_last;
    end
  end

  // Latch the query point and the clamped vertex count for the whole walk.
  always_ff @(posedge clk_i) begin
    if (test_go) begin
      n_q  <= n_clamp;
      px_q <= in_item_i.coord_x;
      pz_q <= in_item_i.coord_z;
    end
  end

  // Hold the previous vertex; each new vertex closes an edge with it.
  always_ff @(posedge clk_i) begin
    if (tag_q.valid) begin
      prev_q <= rd_vtx;
    end
  end

  always_comb begin
    edge_ctl.valid = tag_q.valid && !tag_q.first;
    edge_ctl.last  = tag_q.last;
  end

  // Capture the final count; a short polygon answers outside with no crossings.
  always_ff @(posedge clk_i) begin
    if (test_go) begin
      res_q <= '0;
    end else if (state_q == ST_WAIT && ev_done) begin
      res_q <= ev_count;
    end
  end

  pip_vtx_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (write_go),
    .waddr_i (in_item_i.vertex_slot[SLOT_W-1:0]),
    .wdata_i (wr_vtx),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_vtx)
  );

  pip_edge_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (test_go),
    .edge_i  (edge_ctl),
    .v1_i    (prev_q),
    .v2_i    (rd_vtx),
    .px_i    (px_q),
    .pz_i    (pz_q),
    .done_o  (ev_done),
    .count_o (ev_count)
  );

  // Output register: drop the item when taken, load a new one when free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_item_q.inside_res     <= res_q[0];
      out_item_q.crossing_count <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire
